>>> rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
`default_nettype none

package wbps_pkg;

  localparam int unsigned LenW      = 5;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned PatBytes  = 16;
  localparam int unsigned CareW     = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [LenW-1:0] LenReset = 5'd1;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_BASE_ADDRESS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PatBytes-1:0][7:0] pattern;
    logic [CareW-1:0]         care;
    logic [LenW-1:0]          len;
    logic [AddrW-1:0]         base;
  } cfg_t;

  // Word in the window stage: count of region bytes including this one.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] seen;
  } win_stage_t;

  // Word in the compare stage: only matching words are kept.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] offset;
  } hit_stage_t;

endpackage

`default_nettype wire

>>> rtl/wbps_if.sv
// Handshake channel interfaces for the wildcard byte pattern search block.
`default_nettype none

interface wbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_region;

  modport source (output valid, output data_byte, output last_in_region, input ready);
  modport sink   (input valid, input data_byte, input last_in_region, output ready);
endinterface

interface wbps_match_if;
  logic                         valid;
  logic                         ready;
  logic [wbps_pkg::AddrW-1:0]   match_address;

  modport source (output valid, output match_address, input ready);
  modport sink   (input valid, input match_address, output ready);
endinterface

interface wbps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wbps_pkg::CfgIndexW-1:0] index;
  logic [wbps_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/wildcard_byte_pattern_search.sv
// Top level of the wildcard byte pattern search block.
`default_nettype none

// Scans a byte stream, one byte per cycle while byte_in.ready is high,
// against a pattern of up to PATTERN_MAX bytes with per-byte wildcards, and
// returns base_address plus the region offset of each match start. A new
// byte is accepted every cycle while byte_in.ready is high; the result of
// a byte passes through the window/position register, the masked compare
// register, then the base address add into the output register. Only a
// full output register with match_out.ready low, and compare words queued
// behind it, hold byte_in.ready low. Write configuration only while no word
// is in flight.
module wildcard_byte_pattern_search #(
  parameter int PATTERN_MAX = 16
) (
  input  logic           clk,
  input  logic           rst,
  wbps_byte_if.sink      byte_in,
  wbps_match_if.source   match_out,
  wbps_cfg_if.sink       cfg
);

  wbps_pkg::cfg_t              regs;
  wbps_pkg::win_stage_t        s1;
  wbps_pkg::hit_stage_t        s2;
  logic [PATTERN_MAX-1:0][7:0] window;
  logic                        s1_take;
  logic                        out_take;
  logic                        out_valid;
  logic [wbps_pkg::AddrW-1:0]  addr;

  wbps_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  wbps_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .take    (s1_take),
    .window  (window),
    .s1      (s1)
  );

  wbps_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .clk      (clk),
    .rst      (rst),
    .window   (window),
    .s1       (s1),
    .regs     (regs),
    .out_take (out_take),
    .take     (s1_take),
    .s2       (s2)
  );

  assign out_take                = !out_valid || match_out.ready;
  assign match_out.valid         = out_valid;
  assign match_out.match_address = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s2.valid) begin
      addr <= regs.base + s2.offset;
    end
  end

`ifndef SYNTH
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s2.valid && out_take |=> match_out.valid)
    else $error("match word not loaded into output register");

  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    !s2.valid && out_take |=> !match_out.valid)
    else $error("output register valid without a match word");
`endif

endmodule

`default_nettype wire

>>> rtl/wbps_cfg.sv
// Configuration register file: pattern, care mask, length and base address.
`default_nettype none

module wbps_cfg (
  input  logic             clk,
  input  logic             rst,
  wbps_cfg_if.sink         cfg,
  output wbps_pkg::cfg_t   regs
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern <= '0;
      regs.care    <= '0;
      regs.len     <= wbps_pkg::LenReset;
      regs.base    <= '0;
    end else if (wr) begin
      unique case (wbps_pkg::cfg_reg_t'(cfg.index))
        wbps_pkg::REG_PATTERN_LOW:  regs.pattern[7:0]  <= cfg.data;
        wbps_pkg::REG_PATTERN_HIGH: regs.pattern[15:8] <= cfg.data;
        wbps_pkg::REG_CARE_MASK:    regs.care <= cfg.data[wbps_pkg::CareW-1:0];
        wbps_pkg::REG_PATTERN_LEN:  regs.len  <= cfg.data[wbps_pkg::LenW-1:0];
        wbps_pkg::REG_BASE_ADDRESS: regs.base <= cfg.data;
        default: ;  // unmapped index: drop
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/wbps_window.sv
// Input stage: byte shift window, region position counter and word register.
`default_nettype none

module wbps_window #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  wbps_byte_if.sink                     byte_in,
  input  logic                          take,
  output logic [PATTERN_MAX-1:0][7:0]   window,
  output wbps_pkg::win_stage_t          s1
);

  logic [wbps_pkg::AddrW-1:0] pos;
  logic [wbps_pkg::AddrW-1:0] seen_next;
  logic                       s1_free;
  logic                       accept;

  assign s1_free       = !s1.valid || take;
  assign byte_in.ready = s1_free;
  assign accept        = byte_in.valid && byte_in.ready;
  assign seen_next     = pos + wbps_pkg::AddrW'(1);

  // Newest byte at index 0.
  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= byte_in.data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1.valid <= 1'b0;
    end else begin
      if (accept) begin
        pos     <= byte_in.last_in_region ? '0 : seen_next;
        s1.seen <= seen_next;
      end
      if (s1_free) begin
        s1.valid <= accept;
      end
    end
  end

`ifndef SYNTH
  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.last_in_region |=> pos == '0)
    else $error("region position not cleared after last byte");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    accept && !byte_in.last_in_region |=> pos == $past(pos) + wbps_pkg::AddrW'(1))
    else $error("region position did not advance by one");
`endif

endmodule

`default_nettype wire

>>> rtl/wbps_match.sv
// Compare stage: masked window compare and match start offset.
`default_nettype none

module wbps_match #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [PATTERN_MAX-1:0][7:0]   window,
  input  wbps_pkg::win_stage_t          s1,
  input  wbps_pkg::cfg_t                regs,
  input  logic                          out_take,
  output logic                          take,
  output wbps_pkg::hit_stage_t          s2
);

  localparam int AgeW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [wbps_pkg::LenW-1:0] MaxLen = wbps_pkg::LenW'(PATTERN_MAX);

  logic [wbps_pkg::LenW-1:0]  len_eff;
  logic                       enough;
  logic [PATTERN_MAX-1:0]     mismatch;
  logic                       hit;
  logic [wbps_pkg::AddrW-1:0] offset;

  assign len_eff = (regs.len > MaxLen) ? MaxLen : regs.len;

  // Region must already hold len_eff bytes, counting this one.
  assign enough = (|s1.seen[wbps_pkg::AddrW-1:wbps_pkg::LenW])
               || (s1.seen[wbps_pkg::LenW-1:0] >= len_eff);

  // Pattern byte i lines up with the byte that is len_eff-1-i words old.
  always_comb begin
    logic [wbps_pkg::LenW-1:0] age;
    age      = '0;
    mismatch = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      age = len_eff - wbps_pkg::LenW'(i) - wbps_pkg::LenW'(1);
      mismatch[i] = (wbps_pkg::LenW'(i) < len_eff) && regs.care[i]
                 && (window[age[AgeW-1:0]] != regs.pattern[i]);
    end
  end

  assign hit    = s1.valid && (len_eff != '0) && enough && !(|mismatch);
  assign offset = s1.seen - wbps_pkg::AddrW'(len_eff);
  assign take   = !s2.valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (take) begin
      s2.valid <= hit;
      if (hit) begin
        s2.offset <= offset;
      end
    end
  end

`ifndef SYNTH
  a_hold_hit: assert property (@(posedge clk) disable iff (rst)
    s2.valid && !out_take |=> s2.valid && $stable(s2.offset))
    else $error("stalled match word lost or changed");
`endif

endmodule

`default_nettype wire

>>> tb/sv/wbps_match_checker.sv
// Checker for the wildcard byte pattern search block: mirrors the scan and checks each match word.
`timescale 1ns / 1ps

module wbps_match_checker
  import wbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wbps_byte_if        byte_mon,
  wbps_match_if       match_mon,
  wbps_cfg_if         cfg_mon,
  input  logic        drain_done,
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [PatBytes-1:0][7:0] pat_bytes;
  logic [CareW-1:0]         care_bits;
  logic [LenW-1:0]          pat_len;
  logic [AddrW-1:0]         base_addr;
  logic [7:0]               window [PatBytes];
  logic [AddrW-1:0]         region_pos;
  logic [AddrW-1:0]         match_addrs_due [$];
  int unsigned              errs;
  bit                       leftovers_checked;

  // Shift in one byte; return 1 with the start address when the pattern ends here.
  function automatic bit scan_byte(input logic [7:0] b, input logic is_last,
                                   output logic [AddrW-1:0] start_addr);
    logic [AddrW-1:0] seen;
    int               span;
    bit               hit;
    for (int k = PatBytes - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    seen = region_pos + 1'b1;
    span = (pat_len > PatBytes) ? PatBytes : int'(pat_len);
    hit = 1'b0;
    if (span != 0 && seen >= AddrW'(span)) begin
      hit = 1'b1;
      // pattern byte i sits span-1-i bytes back in the window
      for (int i = 0; i < span; i++)
        if (care_bits[i] && window[span-1-i] != pat_bytes[i]) hit = 1'b0;
    end
    region_pos = is_last ? '0 : seen;
    start_addr = base_addr + (seen - AddrW'(span));
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] due;
    if (rst) begin
      pat_bytes  = '0;
      care_bits  = '0;
      pat_len    = LenReset;
      base_addr  = '0;
      region_pos = '0;
      for (int k = 0; k < PatBytes; k++) window[k] = 8'h00;
      match_addrs_due.delete();
      leftovers_checked = 1'b0;
    end else begin
      if (match_mon.valid && match_mon.ready) begin
        if (match_addrs_due.size() == 0) begin
          $error("match_address: expected no word, actual %h", match_mon.match_address);
          errs++;
        end else begin
          due = match_addrs_due.pop_front();
          if (match_mon.match_address !== due) begin
            $error("match_address: expected %h, actual %h", due, match_mon.match_address);
            errs++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PATTERN_LOW:  pat_bytes[7:0]  = cfg_mon.data;
          REG_PATTERN_HIGH: pat_bytes[15:8] = cfg_mon.data;
          REG_CARE_MASK:    care_bits       = cfg_mon.data[CareW-1:0];
          REG_PATTERN_LEN:  pat_len         = cfg_mon.data[LenW-1:0];
          REG_BASE_ADDRESS: base_addr       = cfg_mon.data;
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) begin
        if (scan_byte(byte_mon.data_byte, byte_mon.last_in_region, addr))
          match_addrs_due.insert(match_addrs_due.size(), addr);
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (match_addrs_due.size() != 0) begin
          $error("match_address: expected %h, actual none; %0d word(s) never arrived",
                 match_addrs_due[0], match_addrs_due.size());
          errs += match_addrs_due.size();
        end
      end
    end
    fail_count <= errs;
    pending    <= match_addrs_due.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench: clock, reset, byte and register stimulus, result sink and verdict.
`timescale 1ns / 1ps

module testbench;
  import wbps_pkg::*;

  localparam int RandomItems = 1700;
  localparam int Phases      = 12;
  localparam int CycleLimit  = 400000;

  typedef enum {CHUNK_FULL, CHUNK_BROKEN, CHUNK_NOISE} chunk_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        drain_done = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int unsigned sent;
  bit          tx_steady;
  bit          rx_steady;

  logic [PatBytes-1:0][7:0] cur_pattern;
  logic [CareW-1:0]         cur_care;
  logic [LenW-1:0]          cur_len;

  wbps_byte_if  byte_if ();
  wbps_match_if match_if ();
  wbps_cfg_if   cfg_if ();

  wildcard_byte_pattern_search dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_if),
    .match_out (match_if),
    .cfg       (cfg_if)
  );

  wbps_match_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .byte_mon   (byte_if),
    .match_mon  (match_if),
    .cfg_mon    (cfg_if),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid          <= 1'b1;
    byte_if.data_byte      <= b;
    byte_if.last_in_region <= is_last;
    do @(posedge clk); while (!byte_if.ready);
    sent++;
  endtask

  task automatic put_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic await_results();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [CareW-1:0] care, input logic [LenW-1:0] len,
                              input logic [AddrW-1:0] base);
    // let bytes that make no match drain out of the pipeline
    await_results();
    repeat (8) @(posedge clk);
    put_reg(REG_PATTERN_LOW, lo);
    put_reg(REG_PATTERN_HIGH, hi);
    put_reg(REG_CARE_MASK, {$urandom, 16'($urandom), care});
    put_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
    put_reg(REG_BASE_ADDRESS, base);
    // unused indexes must leave every register alone
    put_reg(CfgIndexW'(REG_BASE_ADDRESS + $urandom_range(1, 3)), {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
    cur_pattern = {hi, lo};
    cur_care    = care;
    cur_len     = len;
  endtask

  initial begin : result_sink
    int stall;
    match_if.ready = 1'b0;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        match_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      match_if.ready <= 1'b1;
      do @(posedge clk); while (!match_if.valid);
    end
  end

  initial begin : stimulus
    logic [LenW-1:0]  len;
    logic [CareW-1:0] care;
    logic [AddrW-1:0] base;
    logic [7:0]       b;
    chunk_kind_t      kind;
    int               r;
    int               span;
    int               n;
    int               flip;
    int unsigned      phase_start;

    byte_if.valid          = 1'b0;
    byte_if.data_byte      = 8'h00;
    byte_if.last_in_region = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_PATTERN_LOW;
    cfg_if.data            = '0;
    cur_pattern            = '0;
    cur_care               = '0;
    cur_len                = LenReset;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one wildcard byte, so every byte matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);

    // full-length exact pattern ending on the region's last byte; address wraps
    program_regs(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988, '1, 5'd16, '1);
    send_byte(8'h42, 1'b0);
    for (int i = 0; i < PatBytes; i++) send_byte(cur_pattern[i], i == PatBytes - 1);

    // zero length never matches
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd0, {$urandom, $urandom});
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);

    // oversize length acts as the full window; too few bytes so far
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd31, {$urandom, $urandom});
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);

    for (int p = 0; p < Phases; p++) begin
      r = $urandom_range(0, 19);
      if (r < 10)       len = LenW'($urandom_range(1, 6));
      else if (r < 15)  len = LenW'($urandom_range(7, 16));
      else if (r < 17)  len = 5'd16;
      else if (r == 17) len = 5'd0;
      else              len = LenW'($urandom_range(17, 31));
      case ($urandom_range(0, 3))
        0:       care = '1;
        1:       care = '0;
        default: care = CareW'($urandom);
      endcase
      base = ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
      if (p == 0) begin
        len  = 5'd16;
        care = '1;
        base = '0;
      end
      if (p == Phases - 1) begin
        len  = 5'd1;
        care = '0;
        base = '1;
      end
      program_regs({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);

      phase_start = sent;
      while (sent - phase_start < RandomItems / Phases) begin
        span = (cur_len > PatBytes) ? PatBytes : int'(cur_len);
        if (span == 0) span = $urandom_range(1, PatBytes);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: kind = CHUNK_FULL;
          6, 7:             kind = CHUNK_BROKEN;
          default:          kind = CHUNK_NOISE;
        endcase
        tx_steady = ($urandom_range(0, 5) == 0);
        rx_steady = ($urandom_range(0, 5) == 0);
        if (kind == CHUNK_NOISE) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 19) == 0);
        end else begin
          // pattern instance with random wildcard bytes; broken ones are cut or corrupted
          n    = (kind == CHUNK_FULL) ? span : $urandom_range(1, span);
          flip = (kind == CHUNK_BROKEN) ? $urandom_range(0, n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            b = cur_care[i] ? cur_pattern[i] : 8'($urandom);
            if (i == flip) b = b ^ 8'(1 << $urandom_range(0, 7));
            send_byte(b, (i == n - 1) && ($urandom_range(0, 3) == 0));
          end
        end
        if ($urandom_range(0, 39) == 0) await_results();
      end
    end

    await_results();
    repeat (10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
